>>> rtl/erav_pkg.sv
// Package: shared types, constants and arithmetic helpers for the axis rotation block.
package erav_pkg;

    localparam int ERAV_ANGLE_BITS = 16;
    localparam int ERAV_FRAC_BITS  = 14;
    localparam int ERAV_STEPS      = 30;
    localparam int ERAV_PHASE_W    = 32;
    localparam int ERAV_XY_W       = 34;
    localparam int ERAV_Z_W        = 33;

    localparam logic signed [ERAV_XY_W-1:0] ERAV_GAIN = 34'sd652032874;

    // arctangent table, 2^32 units per turn
    localparam logic [31:0] ERAV_ATAN [ERAV_STEPS] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
    };

    typedef enum logic [2:0] {
        AXIS_FRONT = 3'd0,
        AXIS_BACK  = 3'd1,
        AXIS_RIGHT = 3'd2,
        AXIS_LEFT  = 3'd3,
        AXIS_UP    = 3'd4,
        AXIS_DOWN  = 3'd5
    } t_axis;

    typedef struct packed {
        logic signed [ERAV_XY_W-1:0] x;
        logic signed [ERAV_XY_W-1:0] y;
        logic signed [ERAV_Z_W-1:0]  z;
        logic [1:0]                  quad;
    } t_rot;

    typedef struct packed {
        logic        valid;
        logic [2:0]  code;
        t_rot [2:0]  ch;
    } t_stage;

    // Q2.30 product, rounded half up
    function automatic logic signed [ERAV_XY_W-1:0] qmul(
        input logic signed [ERAV_XY_W-1:0] a,
        input logic signed [ERAV_XY_W-1:0] b
    );
        logic signed [2*ERAV_XY_W-1:0] pr;
        pr = a * b + (68'sd1 <<< 29);
        return pr[ERAV_XY_W+29:30];
    endfunction

endpackage

>>> rtl/erav_in_if.sv
// Interface: input channel carrying angles and axis code.
interface erav_in_if
    import erav_pkg::*;
#(
    parameter int ANGLE_BITS = ERAV_ANGLE_BITS
);
    logic                  valid;
    logic                  ready;
    logic [ANGLE_BITS-1:0] angle_x;
    logic [ANGLE_BITS-1:0] angle_y;
    logic [ANGLE_BITS-1:0] angle_z;
    logic [2:0]            axis_code;

    modport source (output valid, angle_x, angle_y, angle_z, axis_code, input ready);
    modport sink   (input valid, angle_x, angle_y, angle_z, axis_code, output ready);
endinterface

>>> rtl/erav_out_if.sv
// Interface: output channel carrying the rotated vector.
interface erav_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] vec_x;
    logic signed [15:0] vec_y;
    logic signed [15:0] vec_z;

    modport source (output valid, vec_x, vec_y, vec_z, input ready);
    modport sink   (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

>>> rtl/erav_cordic_cell.sv
// CORDIC cell: one micro-rotation for all three angles.
module erav_cordic_cell
    import erav_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_stage i_stage,
    output t_stage o_stage
);
    t_stage r_stage;
    t_stage n_stage;

    localparam logic signed [ERAV_Z_W-1:0] ATAN = {1'b0, ERAV_ATAN[STEP]};

    always_comb begin
        logic signed [ERAV_XY_W-1:0] dx;
        logic signed [ERAV_XY_W-1:0] dy;
        n_stage = i_stage;
        for (int k = 0; k < 3; k++) begin
            dx = i_stage.ch[k].y >>> STEP;
            dy = i_stage.ch[k].x >>> STEP;
            if (!i_stage.ch[k].z[ERAV_Z_W-1]) begin
                n_stage.ch[k].x = i_stage.ch[k].x - dx;
                n_stage.ch[k].y = i_stage.ch[k].y + dy;
                n_stage.ch[k].z = i_stage.ch[k].z - ATAN;
            end else begin
                n_stage.ch[k].x = i_stage.ch[k].x + dx;
                n_stage.ch[k].y = i_stage.ch[k].y - dy;
                n_stage.ch[k].z = i_stage.ch[k].z + ATAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;
endmodule

>>> rtl/erav_matrix.sv
// Matrix column: quadrant fix, Q2.30 products, rounding and output register.
module erav_matrix
    import erav_pkg::*;
#(
    parameter int FRAC_BITS = ERAV_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  t_stage             i_stage,
    output logic               o_valid,
    output logic signed [15:0] o_vec_x,
    output logic signed [15:0] o_vec_y,
    output logic signed [15:0] o_vec_z
);
    localparam int SH     = 30 - FRAC_BITS;
    localparam int RND_SH = (SH > 0) ? SH - 1 : 0;
    localparam int W      = ERAV_XY_W;

    typedef logic signed [W-1:0] t_val;

    function automatic logic [15:0] to_out(input t_val v, input logic neg);
        logic signed [W:0] r;
        logic signed [W:0] one;
        one = (W+1)'(1) <<< FRAC_BITS;
        r   = (W+1)'(v);
        if (SH > 0) begin
            r = (r + ((W+1)'(1) <<< RND_SH)) >>> SH;
        end
        if (r > one) r = one;
        if (r < -one) r = -one;
        if (neg) r = -r;
        return r[15:0];
    endfunction

    // quadrant stage
    logic       r_q_valid;
    logic [2:0] r_q_code;
    t_val       r_c [3];
    t_val       r_s [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
        end else if (i_en) begin
            r_q_valid <= i_stage.valid;
            r_q_code  <= i_stage.code;
            for (int k = 0; k < 3; k++) begin
                unique case (i_stage.ch[k].quad)
                    2'd0: begin r_c[k] <= i_stage.ch[k].x;  r_s[k] <= i_stage.ch[k].y;  end
                    2'd1: begin r_c[k] <= -i_stage.ch[k].y; r_s[k] <= i_stage.ch[k].x;  end
                    2'd2: begin r_c[k] <= -i_stage.ch[k].x; r_s[k] <= -i_stage.ch[k].y; end
                    default: begin r_c[k] <= i_stage.ch[k].y; r_s[k] <= -i_stage.ch[k].x; end
                endcase
            end
        end
    end

    // first product stage
    logic       r_p1_valid;
    logic [2:0] r_p1_code;
    t_val       r_a, r_t0, r_t1, r_m2, r_cz, r_sz;
    t_val       n_a, n_t0, n_t1, n_m2;

    always_comb begin
        n_a = '0; n_t0 = '0; n_t1 = '0; n_m2 = '0;
        unique case (t_axis'(r_q_code))
            AXIS_FRONT, AXIS_BACK: begin
                n_a  = qmul(r_c[0], r_s[1]);
                n_t0 = qmul(r_s[0], r_s[2]);
                n_t1 = qmul(r_s[0], r_c[2]);
                n_m2 = qmul(r_c[0], r_c[1]);
            end
            AXIS_UP, AXIS_DOWN: begin
                n_a  = qmul(r_s[0], r_s[1]);
                n_t0 = qmul(r_c[0], r_s[2]);
                n_t1 = qmul(r_c[0], r_c[2]);
                n_m2 = qmul(r_s[0], r_c[1]);
            end
            AXIS_RIGHT, AXIS_LEFT: begin
                n_a  = r_c[1];
                n_m2 = -r_s[1];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (i_en) begin
            r_p1_valid <= r_q_valid;
            r_p1_code  <= r_q_code;
            r_a  <= n_a;
            r_t0 <= n_t0;
            r_t1 <= n_t1;
            r_m2 <= n_m2;
            r_cz <= r_c[2];
            r_sz <= r_s[2];
        end
    end

    // second product stage
    logic       r_p2_valid;
    logic [2:0] r_p2_code;
    t_val       r_m0, r_m1, r_m2b;
    t_val       n_m0, n_m1;

    always_comb begin
        t_val pa;
        t_val pb;
        pa = qmul(r_a, r_cz);
        pb = qmul(r_a, r_sz);
        if (r_p1_code == AXIS_UP || r_p1_code == AXIS_DOWN) begin
            n_m0 = pa - r_t0;
            n_m1 = pb + r_t1;
        end else begin
            n_m0 = pa + r_t0;
            n_m1 = pb - r_t1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid <= 1'b0;
        end else if (i_en) begin
            r_p2_valid <= r_p1_valid;
            r_p2_code  <= r_p1_code;
            r_m0  <= n_m0;
            r_m1  <= n_m1;
            r_m2b <= r_m2;
        end
    end

    // output stage
    logic               r_valid;
    logic signed [15:0] r_vx, r_vy, r_vz;
    logic               n_neg;
    logic               n_zero;

    always_comb begin
        n_neg  = 1'b0;
        n_zero = 1'b0;
        unique case (t_axis'(r_p2_code))
            AXIS_FRONT, AXIS_LEFT, AXIS_DOWN: n_neg = 1'b1;
            AXIS_BACK, AXIS_RIGHT, AXIS_UP:   n_neg = 1'b0;
            default:                          n_zero = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= r_p2_valid;
            r_vx <= n_zero ? 16'sd0 : to_out(r_m0, n_neg);
            r_vy <= n_zero ? 16'sd0 : to_out(r_m1, n_neg);
            r_vz <= n_zero ? 16'sd0 : to_out(r_m2b, n_neg);
        end
    end

    assign o_valid = r_valid;
    assign o_vec_x = r_vx;
    assign o_vec_y = r_vy;
    assign o_vec_z = r_vz;
endmodule

>>> rtl/euler_rotate_axis_vector.sv
// Pipeline: 30 CORDIC cells, then quadrant, two product stages and out, each one registered.
// Throughput: one word per cycle; the whole cell chain advances whenever the output
// register is empty or being taken, so ready follows the output side only.
// Reset: synchronous active low, clears every stage valid bit; payload is not reset.
// No clearing pass and no stored state beyond the pipeline.
// Top level: ZYX Euler rotation of a chosen unit axis vector.
module euler_rotate_axis_vector
    import erav_pkg::*;
#(
    parameter int ANGLE_BITS = ERAV_ANGLE_BITS,
    parameter int FRAC_BITS  = ERAV_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    erav_in_if.sink     i_in,
    erav_out_if.source  o_out
);
    localparam int PAD = ERAV_PHASE_W - ANGLE_BITS;

    logic   w_en;
    logic   w_valid;
    t_stage w_stage [ERAV_STEPS+1];

    assign w_en       = !w_valid || o_out.ready;
    assign i_in.ready = w_en;

    // seed word: quadrant split and residual phase
    always_comb begin
        logic [ERAV_PHASE_W-1:0] ph [3];
        logic [ERAV_PHASE_W-1:0] r;
        ph[0] = {i_in.angle_x, {PAD{1'b0}}};
        ph[1] = {i_in.angle_y, {PAD{1'b0}}};
        ph[2] = {i_in.angle_z, {PAD{1'b0}}};
        w_stage[0].valid = i_in.valid;
        w_stage[0].code  = i_in.axis_code;
        for (int k = 0; k < 3; k++) begin
            r = ph[k] + 32'h2000_0000;
            w_stage[0].ch[k].quad = r[31:30];
            w_stage[0].ch[k].x    = ERAV_GAIN;
            w_stage[0].ch[k].y    = '0;
            w_stage[0].ch[k].z    = $signed({3'b000, r[29:0]}) - 33'sh0_2000_0000;
        end
    end

    for (genvar g = 0; g < ERAV_STEPS; g++) begin : g_cell
        erav_cordic_cell #(.STEP(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (w_stage[g]),
            .o_stage (w_stage[g+1])
        );
    end

    erav_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_stage (w_stage[ERAV_STEPS]),
        .o_valid (w_valid),
        .o_vec_x (o_out.vec_x),
        .o_vec_y (o_out.vec_y),
        .o_vec_z (o_out.vec_z)
    );

    assign o_out.valid = w_valid;

    localparam logic signed [15:0] ONE = 16'(1 << ((FRAC_BITS > 14) ? 14 : FRAC_BITS));

    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready == (!o_out.valid || o_out.ready))
        else $error("input ready does not follow output side");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (FRAC_BITS <= 14) |->
            (o_out.vec_x <= ONE) && (o_out.vec_x >= -ONE) &&
            (o_out.vec_y <= ONE) && (o_out.vec_y >= -ONE) &&
            (o_out.vec_z <= ONE) && (o_out.vec_z >= -ONE))
        else $error("output component beyond unit range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.vec_x))
        else $error("stalled word changed");
endmodule

>>> verif/tb_euler_rotate_axis_vector.sv
// Testbench: drives angle/axis words into the rotation block and checks each vector.
`timescale 1ns / 100ps

class rot_scoreboard;
    typedef struct {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] vz;
    } vec_t;

    vec_t pending[$];
    int   errors;

    // floor shift of a signed 64-bit value
    static function longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    static function void trig(logic [15:0] ang, output longint c, output longint s);
        logic [31:0] ph, r;
        longint x, y, z, dx, dy;
        logic [1:0] q;
        ph = {ang, 16'h0};
        r  = ph + 32'h2000_0000;
        q  = r[31:30];
        z  = longint'({2'b00, r[29:0]}) - 64'sh2000_0000;
        x  = 652032874;
        y  = 0;
        for (int i = 0; i < erav_pkg::ERAV_STEPS; i++) begin
            dx = fshr(y, i);
            dy = fshr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(erav_pkg::ERAV_ATAN[i]);
            end else begin
                x += dx; y -= dy; z += longint'(erav_pkg::ERAV_ATAN[i]);
            end
        end
        case (q)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    static function longint prod(longint a, longint b);
        return fshr(a * b + (64'sd1 <<< 29), 30);
    endfunction

    static function logic signed [15:0] to_q14(longint v, bit neg);
        longint r;
        r = fshr(v + (64'sd1 <<< 15), 16);
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        if (neg) r = -r;
        return r[15:0];
    endfunction

    function void note_word(logic [15:0] ax, logic [15:0] ay, logic [15:0] az, logic [2:0] code);
        longint cx, sx, cy, sy, cz, sz;
        longint m0, m1, m2;
        bit neg;
        vec_t e;
        trig(ax, cx, sx);
        trig(ay, cy, sy);
        trig(az, cz, sz);
        neg = (code == erav_pkg::AXIS_FRONT) || (code == erav_pkg::AXIS_LEFT)
            || (code == erav_pkg::AXIS_DOWN);
        case (code)
            erav_pkg::AXIS_FRONT, erav_pkg::AXIS_BACK: begin
                m0 = prod(prod(cx, sy), cz) + prod(sx, sz);
                m1 = prod(prod(cx, sy), sz) - prod(sx, cz);
                m2 = prod(cx, cy);
            end
            erav_pkg::AXIS_RIGHT, erav_pkg::AXIS_LEFT: begin
                m0 = prod(cy, cz);
                m1 = prod(cy, sz);
                m2 = -sy;
            end
            erav_pkg::AXIS_UP, erav_pkg::AXIS_DOWN: begin
                m0 = prod(prod(sx, sy), cz) - prod(cx, sz);
                m1 = prod(prod(sx, sy), sz) + prod(cx, cz);
                m2 = prod(sx, cy);
            end
            default: begin
                pending.push_back('{16'sd0, 16'sd0, 16'sd0});
                return;
            end
        endcase
        e.vx = to_q14(m0, neg);
        e.vy = to_q14(m1, neg);
        e.vz = to_q14(m2, neg);
        pending.push_back(e);
    endfunction

    task report(string msg);
        $display("MISMATCH: %s", msg);
        errors++;
    endtask

    task check_vec(logic signed [15:0] vx, logic signed [15:0] vy, logic signed [15:0] vz);
        vec_t e;
        if (pending.size() == 0) begin
            report($sformatf("unexpected word %0d %0d %0d", vx, vy, vz));
            return;
        end
        e = pending.pop_front();
        if (vx !== e.vx) report($sformatf("vec_x got %0d want %0d", vx, e.vx));
        if (vy !== e.vy) report($sformatf("vec_y got %0d want %0d", vy, e.vy));
        if (vz !== e.vz) report($sformatf("vec_z got %0d want %0d", vz, e.vz));
    endtask
endclass

module tb_euler_rotate_axis_vector;
    import erav_pkg::*;

    localparam int LATENCY   = 34;
    localparam int N_RANDOM  = 1400;
    localparam int MAX_CYCLE = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   cycle = 0;
    bit   calm = 1'b0;     // no idling on either side
    bit   hold_sink = 1'b0;
    bit   src_done = 1'b0;

    erav_in_if  in_ch();
    erav_out_if out_ch();

    rot_scoreboard board = new();

    euler_rotate_axis_vector dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.angle_x = '0;
        in_ch.angle_y = '0;
        in_ch.angle_z = '0;
        in_ch.axis_code = '0;
        out_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle >= MAX_CYCLE) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // note accepted words, check results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                board.note_word(in_ch.angle_x, in_ch.angle_y, in_ch.angle_z, in_ch.axis_code);
            if (out_ch.valid && out_ch.ready)
                board.check_vec(out_ch.vec_x, out_ch.vec_y, out_ch.vec_z);
        end
    end

    // receiver: random stalls, or a long hold-off when asked
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_sink)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= calm || ($urandom_range(99) >= 38);
    end

    // returns at the falling edge after acceptance with valid still high;
    // the next call or the caller drops it
    task send_word(logic [15:0] ax, logic [15:0] ay, logic [15:0] az, logic [2:0] code);
        while (!calm && $urandom_range(99) < 38) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.angle_x   <= ax;
        in_ch.angle_y   <= ay;
        in_ch.angle_z   <= az;
        in_ch.axis_code <= code;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task drain();
        in_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
    endtask

    function logic [15:0] rand_angle();
        case ($urandom_range(5))
            0: return 16'(16'h4000 * $urandom_range(3) + $urandom_range(2) - 1);
            1: return 16'(16'h2000 * $urandom_range(7));
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] edges [6];
        edges = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h2000};
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: every axis code, quadrant edges and wrap values
        for (int c = 0; c < 8; c++)
            send_word(16'h0000, 16'h0000, 16'h0000, 3'(c));
        for (int k = 0; k < 6; k++)
            send_word(edges[k], edges[(k + 1) % 6], edges[(k + 3) % 6], 3'(k));
        send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7);
        send_word(16'h5555, 16'hAAAA, 16'h1234, 3'd6);
        send_word(16'hFFFF, 16'h8000, 16'h7FFF, 3'd0);

        // sender pauses until the pipe is empty
        drain();

        // receiver holds off while words keep coming
        fork
            begin
                hold_sink = 1'b1;
                repeat (120) @(negedge i_clk);
                hold_sink = 1'b0;
            end
            begin
                calm = 1'b1;
                for (int n = 0; n < 60; n++)
                    send_word(rand_angle(), rand_angle(), rand_angle(), 3'($urandom));
                calm = 1'b0;
                in_ch.valid <= 1'b0;
                @(negedge i_clk);
            end
        join

        for (int n = 0; n < N_RANDOM; n++) begin
            calm = (n >= 400 && n < 600);
            send_word(rand_angle(), rand_angle(), rand_angle(),
                      ($urandom_range(9) == 0) ? 3'($urandom_range(7, 6))
                                               : 3'($urandom_range(5)));
        end
        calm = 1'b0;
        drain();
        repeat (LATENCY + 10) @(negedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

>>> euler_rotate_axis_vector.f
rtl/erav_pkg.sv
rtl/erav_in_if.sv
rtl/erav_out_if.sv
rtl/erav_cordic_cell.sv
rtl/erav_matrix.sv
rtl/euler_rotate_axis_vector.sv
verif/tb_euler_rotate_axis_vector.sv
